FILE: rtl/core/fdpc_pkg.sv
// types and constants shared by the frame deframer with ones-count check
// used by the front, back and top modules under rtl/core
package fdpc_pkg;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	localparam logic [6:0] POS_HEADER_CMD = 7'd0;
	localparam logic [6:0] POS_HEADER_LEN = 7'd1;
	localparam logic [6:0] POS_FIRST_DATA = 7'd2;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_start;
	} in_item_t;

	typedef struct packed {
		logic       out_kind;
		logic [7:0] payload_byte;
		logic [5:0] payload_index;
		logic [3:0] command;
		logic [5:0] length;
		logic [7:0] received_check;
		logic [9:0] computed_ones;
		logic       frame_ok;
		logic       last;
	} out_item_t;

	// classified byte passed from front to back through the queue
	typedef struct packed {
		logic       kind;
		logic [7:0] data;
		logic [5:0] index;
		logic [3:0] command;
		logic [5:0] length;
		logic [9:0] ones;
	} rec_t;

	function automatic logic [3:0] ones_in_byte(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd0;
		for (int k = 0; k < 8; k++) begin
			n = n + {3'd0, b[k]};
		end
		return n;
	endfunction

endpackage

FILE: rtl/core/fdpc_front.sv
// front end: tracks frame position, counts one bits and classifies each byte
// depends on fdpc_pkg
module fdpc_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              byte_valid,
	output logic              byte_stall,
	input  fdpc_pkg::in_item_t byte_item,
	input  logic              q_full,
	output logic              q_push,
	output fdpc_pkg::rec_t    q_rec
);
	import fdpc_pkg::*;

	logic [6:0] pos_q;
	logic [3:0] cmd_q;
	logic [5:0] len_q;
	logic [9:0] ones_q;

	logic       take;
	logic [6:0] pos;
	logic [6:0] check_pos;
	logic [9:0] ones_sum;
	logic [6:0] data_index;

	assign byte_stall = q_full;
	assign take       = byte_valid && !q_full;
	assign pos        = byte_item.frame_start ? POS_HEADER_CMD : pos_q;
	assign check_pos  = {1'b0, len_q} + POS_FIRST_DATA;
	assign ones_sum   = ones_q + {6'd0, ones_in_byte(byte_item.rx_byte)};
	assign data_index = pos - POS_FIRST_DATA;

	always_comb begin
		q_push        = 1'b0;
		q_rec.kind    = KIND_PAYLOAD;
		q_rec.data    = byte_item.rx_byte;
		q_rec.index   = data_index[5:0];
		q_rec.command = cmd_q;
		q_rec.length  = len_q;
		q_rec.ones    = ones_q;
		if (take && pos != POS_HEADER_CMD && pos != POS_HEADER_LEN) begin
			q_push = 1'b1;
			// anything at or past the check position closes the frame
			if (pos >= check_pos) begin
				q_rec.kind = KIND_VERDICT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= POS_HEADER_CMD;
			cmd_q  <= 4'd0;
			len_q  <= 6'd0;
			ones_q <= 10'd0;
		end else if (take) begin
			if (pos == POS_HEADER_CMD) begin
				cmd_q  <= byte_item.rx_byte[5:2];
				ones_q <= {6'd0, ones_in_byte(byte_item.rx_byte)};
				pos_q  <= POS_HEADER_LEN;
			end else if (pos == POS_HEADER_LEN) begin
				len_q  <= byte_item.rx_byte[6:1];
				ones_q <= ones_sum;
				pos_q  <= POS_FIRST_DATA;
			end else if (pos < check_pos) begin
				ones_q <= ones_sum;
				pos_q  <= pos + 7'd1;
			end else begin
				pos_q <= POS_HEADER_CMD;
			end
		end
	end

endmodule

FILE: rtl/core/fdpc_queue.sv
// short register queue between front and back
// generic, no package dependency
module fdpc_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             not_empty,
	output logic [WIDTH-1:0] rdata
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full      = (cnt_q == FULL_CNT);
	assign not_empty = (cnt_q != '0);
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign rdata     = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + PW'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

FILE: rtl/core/fdpc_back.sv
// back end: forms payload results and frame verdicts into the output register
// depends on fdpc_pkg
module fdpc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_not_empty,
	input  fdpc_pkg::rec_t      q_rec,
	output logic                q_pop,
	output logic                result_valid,
	input  logic                result_stall,
	output fdpc_pkg::out_item_t result_item
);
	import fdpc_pkg::*;

	logic      valid_q;
	out_item_t item_q;
	out_item_t next_item;

	assign q_pop        = q_not_empty && (!valid_q || !result_stall);
	assign result_valid = valid_q;
	assign result_item  = item_q;

	always_comb begin
		next_item          = '0;
		next_item.out_kind = q_rec.kind;
		next_item.command  = q_rec.command;
		next_item.length   = q_rec.length;
		if (q_rec.kind == KIND_VERDICT) begin
			next_item.received_check = q_rec.data;
			next_item.computed_ones  = q_rec.ones;
			next_item.frame_ok       = (q_rec.ones[7:0] == q_rec.data);
			next_item.last           = 1'b1;
		end else begin
			next_item.payload_byte  = q_rec.data;
			next_item.payload_index = q_rec.index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (q_pop) begin
			valid_q <= 1'b1;
		end else if (!result_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			item_q <= next_item;
		end
	end

endmodule

FILE: rtl/core/frame_deframer_popcount_check.sv
// Frame deframer with ones-count check. One received byte is taken per cycle
// whenever the internal queue has room, so the sustained rate is one byte a
// cycle; the front end's position and one-bit counter update in that single
// cycle. A payload byte comes out with its index, the check byte gives the
// verdict, header bytes give nothing. Results leave through a registered
// output behind the queue; the QUEUE_DEPTH-entry queue between the front
// and back ends absorbs output stalls before the input is stalled.
// frame_start high on a byte drops any frame in progress and starts anew.
module frame_deframer_popcount_check #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                byte_valid,
	output logic                byte_stall,
	input  fdpc_pkg::in_item_t  byte_item,
	output logic                result_valid,
	input  logic                result_stall,
	output fdpc_pkg::out_item_t result_item
);
	import fdpc_pkg::*;

	logic q_push;
	logic q_full;
	logic q_pop;
	logic q_not_empty;
	rec_t push_rec;
	rec_t head_rec;

	fdpc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_stall (byte_stall),
		.byte_item  (byte_item),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_rec      (push_rec)
	);

	fdpc_queue #(
		.WIDTH ($bits(rec_t)),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.wdata     (push_rec),
		.full      (q_full),
		.pop       (q_pop),
		.not_empty (q_not_empty),
		.rdata     (head_rec)
	);

	fdpc_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_not_empty  (q_not_empty),
		.q_rec        (head_rec),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result_item  (result_item)
	);

endmodule
